>>> rtl/lfc_pkg.sv
// shared types and constants for the lsa fletcher checksum block
package lfc_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2,
        ST_LONG     = 2'd3
    } lfc_status_t;

    localparam logic [7:0]  MOD_VAL      = 8'd255;
    localparam logic [15:0] AGE_BYTES    = 16'd2;
    localparam logic [15:0] CKSUM_OFFSET = 16'd16;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    // summary of one finished message handed to the finishing stage
    typedef struct packed {
        logic       too_long;
        logic       too_short;
        logic       gen_mode;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] dist_mod;   // (length - 17) mod 255
    } lfc_final_t;

    // add two residues mod 255, each below 255
    function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MOD_VAL}) begin
            s = s - {1'b0, MOD_VAL};
        end
        return s[7:0];
    endfunction

endpackage

>>> rtl/lfc_accum.sv
// input register and running mod-255 sums over the bytes of a message
module lfc_accum #(
    parameter int MIN_LENGTH = 20,
    parameter int MAX_LENGTH = 65535
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [7:0]         s_data,
    input  logic               s_last,
    output logic               fin_valid,
    input  logic               fin_ready,
    output lfc_pkg::lfc_final_t fin
);
    import lfc_pkg::*;

    localparam logic [15:0] MAX_IDX   = 16'(MAX_LENGTH);
    localparam logic [15:0] SHORT_IDX = 16'(MIN_LENGTH - 1);

    logic        in_valid_reg, in_valid_next;
    logic        in_mode_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    logic [15:0] count_reg, count_next;
    logic [7:0]  pos_mod_reg, pos_mod_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic        mode_reg, mode_next;
    logic        ovf_reg, ovf_next;

    logic        rec_valid_reg, rec_valid_next;
    lfc_final_t  rec_reg, rec_next;

    logic        rec_free;
    logic        in_go;
    logic        s_take;
    logic        cur_mode;
    logic        cur_ovf;
    logic [7:0]  byte_val;
    logic [7:0]  new_a;
    logic [7:0]  new_b;

    // handshake between input register and record register
    assign rec_free = !rec_valid_reg || fin_ready;
    assign in_go    = in_valid_reg && (!in_last_reg || rec_free);
    assign s_ready  = !in_valid_reg || in_go;
    assign s_take   = s_valid && s_ready;

    // running sums for the byte held in the input register
    always_comb begin
        cur_mode = (count_reg == '0) ? in_mode_reg : mode_reg;
        cur_ovf  = ovf_reg || (count_reg >= MAX_IDX);
        byte_val = in_data_reg;
        if (cur_mode && (count_reg == CKSUM_OFFSET || count_reg == CKSUM_OFFSET + 16'd1)) begin
            byte_val = '0;
        end
        if (count_reg >= AGE_BYTES) begin
            new_a = mod_add(sum_a_reg, byte_val);
            new_b = mod_add(sum_b_reg, new_a);
        end else begin
            new_a = sum_a_reg;
            new_b = sum_b_reg;
        end
    end

    // next state of the message accumulator
    always_comb begin
        count_next   = count_reg;
        pos_mod_next = pos_mod_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        mode_next    = mode_reg;
        ovf_next     = ovf_reg;
        if (in_go) begin
            if (in_last_reg) begin
                count_next   = '0;
                pos_mod_next = '0;
                sum_a_next   = '0;
                sum_b_next   = '0;
                mode_next    = 1'b0;
                ovf_next     = 1'b0;
            end else begin
                count_next   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;
                pos_mod_next = (pos_mod_reg == MOD_VAL - 8'd1) ? 8'd0 : pos_mod_reg + 8'd1;
                sum_a_next   = new_a;
                sum_b_next   = new_b;
                mode_next    = cur_mode;
                ovf_next     = cur_ovf;
            end
        end
    end

    // message summary on the final byte
    always_comb begin
        rec_next           = rec_reg;
        rec_valid_next     = rec_valid_reg;
        if (in_go && in_last_reg) begin
            rec_valid_next     = 1'b1;
            rec_next.too_long  = cur_ovf;
            rec_next.too_short = count_reg < SHORT_IDX;
            rec_next.gen_mode  = cur_mode;
            rec_next.sum_a     = new_a;
            rec_next.sum_b     = new_b;
            // index minus 16 taken mod 255
            rec_next.dist_mod  = (pos_mod_reg >= 8'd16) ? pos_mod_reg - 8'd16
                                                        : pos_mod_reg + 8'd239;
        end else if (fin_ready) begin
            rec_valid_next = 1'b0;
        end
        in_valid_next = s_take ? 1'b1 : (in_go ? 1'b0 : in_valid_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            rec_valid_reg <= 1'b0;
            count_reg     <= '0;
            pos_mod_reg   <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            mode_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            rec_valid_reg <= rec_valid_next;
            count_reg     <= count_next;
            pos_mod_reg   <= pos_mod_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            mode_reg      <= mode_next;
            ovf_reg       <= ovf_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_mode_reg <= s_mode;
            in_data_reg <= s_data;
            in_last_reg <= s_last;
        end
        rec_reg <= rec_next;
    end

    assign fin_valid = rec_valid_reg;
    assign fin       = rec_reg;

    // sums always stay proper residues
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_a_reg != MOD_VAL && sum_b_reg != MOD_VAL)
        else $error("running sum left the mod 255 range");

    // start of a message has clean sums
    a_clean_start: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> (sum_a_reg == '0 && sum_b_reg == '0 && !ovf_reg))
        else $error("sums not cleared at message start");

    // position residue tracks the byte count
    a_pos_track: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < 16'd255 |-> pos_mod_reg == count_reg[7:0])
        else $error("position residue out of step");

    // a held final byte is not dropped while the record register is busy
    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && !rec_free) |=> in_valid_reg)
        else $error("final byte lost while stalled");
endmodule

>>> rtl/lfc_finish.sv
// checksum byte computation and result register
module lfc_finish (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fin_valid,
    output logic               fin_ready,
    input  lfc_pkg::lfc_final_t fin,
    output logic               m_valid,
    input  logic               m_ready,
    output lfc_pkg::lfc_status_t m_status,
    output logic [7:0]         m_check_x,
    output logic [7:0]         m_check_y
);
    import lfc_pkg::*;

    logic        m_valid_reg, m_valid_next;
    lfc_status_t status_reg, status_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;

    logic [15:0] prod;
    logic [7:0]  prod_mod;
    logic [7:0]  x_mod;
    logic [7:0]  x_val;
    logic [8:0]  y_raw;
    logic [7:0]  y_val;
    logic        load;

    assign fin_ready = !m_valid_reg || m_ready;
    assign load      = fin_valid && fin_ready;

    // x = (dist * sum_a - sum_b) mod 255, zero raised to 255
    always_comb begin
        prod     = {8'd0, fin.dist_mod} * {8'd0, fin.sum_a};
        prod_mod = mod_add(prod[15:8], prod[7:0]);
        x_mod    = mod_add(prod_mod, MOD_VAL - fin.sum_b);
        x_val    = (x_mod == '0) ? MOD_VAL : x_mod;
        // y = 510 - sum_a - x, folded back below 256
        y_raw    = 9'd510 - {1'b0, fin.sum_a} - {1'b0, x_val};
        y_val    = (y_raw > 9'd255) ? 8'(y_raw - 9'd255) : y_raw[7:0];
    end

    // status selection
    always_comb begin
        status_next  = status_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        if (load) begin
            x_next = '0;
            y_next = '0;
            if (fin.too_long) begin
                status_next = ST_LONG;
            end else if (fin.too_short) begin
                status_next = ST_SHORT;
            end else if (!fin.gen_mode) begin
                status_next = (fin.sum_a == '0 && fin.sum_b == '0) ? ST_OK : ST_MISMATCH;
            end else begin
                status_next = ST_OK;
                x_next      = x_val;
                y_next      = y_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = status_reg;
    assign m_check_x = x_reg;
    assign m_check_y = y_reg;

    // checksum bytes appear only with an ok status
    a_zero_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != ST_OK) |-> (x_reg == '0 && y_reg == '0))
        else $error("checksum bytes on a failing result");

    // generated checksum bytes are never zero
    a_gen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && x_reg != '0) |-> (y_reg != '0 && status_reg == ST_OK))
        else $error("generated checksum byte is zero");
endmodule

>>> rtl/lsa_fletcher_checksum.sv
// Fletcher checksum verify/generate over one link-state advertisement byte stream
// A final byte's result moves through the record register into the result register.
// One byte per cycle unless stalled; running sums update once per byte in one stage.
// Each message gives one result, on its final byte; other bytes give none.
// Reset: aresetn, synchronous active low, clears sums, byte count and all valid flags.
module lsa_fletcher_checksum #(
    parameter int MIN_LENGTH = 20,
    parameter int MAX_LENGTH = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] check_x, [15:8] check_y
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import lfc_pkg::*;

    logic        fin_valid;
    logic        fin_ready;
    lfc_final_t  fin;
    lfc_status_t status;
    logic [7:0]  check_x;
    logic [7:0]  check_y;

    // running sums per byte
    lfc_accum #(
        .MIN_LENGTH (MIN_LENGTH),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_mode    (s_axis_tuser),
        .s_data    (s_axis_tdata),
        .s_last    (s_axis_tlast),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    // checksum bytes and status per message
    lfc_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_status  (status),
        .m_check_x (check_x),
        .m_check_y (check_y)
    );

    assign m_axis_tdata = {check_y, check_x};
    assign m_axis_tuser = status;
endmodule

>>> dv/tb_lsa_fletcher_checksum.sv
// self-checking testbench for the lsa fletcher checksum block
`timescale 1ns / 100ps

module tb_lsa_fletcher_checksum;
    import lfc_pkg::*;

    localparam int MIN_LEN     = 20;
    localparam int MAX_LEN     = 65535;
    localparam int RAND_BYTES  = 1710;
    localparam int CYCLE_LIMIT = 4000000;

    // one finished message as seen on the result channel
    typedef struct packed {
        lfc_status_t status;
        logic [7:0]  cx;
        logic [7:0]  cy;
    } chk_result_t;

    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAND,
        FILL_SEALED
    } fill_kind_t;

    // one directed message; typed rows carry their own expected result
    typedef struct packed {
        logic        md;
        logic [16:0] len;
        fill_kind_t  fill;
        logic        typed;
        lfc_status_t st;
        logic [7:0]  x;
        logic [7:0]  y;
    } msg_row_t;

    localparam msg_row_t DIRECTED [11] = '{
        '{1'b0, 17'd1,     FILL_ZERO,   1'b1, ST_SHORT, 8'd0,   8'd0},
        '{1'b1, 17'd2,     FILL_ONES,   1'b1, ST_SHORT, 8'd0,   8'd0},
        '{1'b0, 17'd19,    FILL_ONES,   1'b1, ST_SHORT, 8'd0,   8'd0},
        '{1'b1, 17'd19,    FILL_RAND,   1'b1, ST_SHORT, 8'd0,   8'd0},
        '{1'b0, 17'd20,    FILL_ZERO,   1'b1, ST_OK,    8'd0,   8'd0},
        '{1'b0, 17'd20,    FILL_ONES,   1'b1, ST_OK,    8'd0,   8'd0},
        '{1'b1, 17'd20,    FILL_ZERO,   1'b1, ST_OK,    8'd255, 8'd255},
        '{1'b1, 17'd20,    FILL_ONES,   1'b1, ST_OK,    8'd255, 8'd255},
        '{1'b0, 17'd20,    FILL_RAND,   1'b0, ST_OK,    8'd0,   8'd0},
        '{1'b1, 17'd64,    FILL_RAND,   1'b0, ST_OK,    8'd0,   8'd0},
        '{1'b0, 17'd32,    FILL_SEALED, 1'b0, ST_OK,    8'd0,   8'd0}
    };

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;   // [0] mode
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] check_x, [15:8] check_y
    logic [1:0]  m_axis_tuser;           // [1:0] status

    // mirror of the block state
    logic [15:0] msg_count = '0;
    logic [7:0]  run_a     = '0;
    logic [7:0]  run_b     = '0;
    logic        msg_mode  = 1'b0;
    logic        msg_long  = 1'b0;

    chk_result_t pending_results[$];
    logic [7:0]  msg_q[$];
    bit          quiet_run  = 1'b0;
    int          mismatches = 0;
    int          cycle_cnt  = 0;
    int          stall_left = 0;

    lsa_fletcher_checksum #(
        .MIN_LENGTH(MIN_LEN),
        .MAX_LENGTH(MAX_LEN)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // running fletcher sums per byte; returns 1 with the result on a final byte
    function automatic bit fletcher_predict(input logic md, input logic [7:0] b,
                                            input logic lst, output chk_result_t res);
        int         idx;
        int         len;
        int         x;
        int         y;
        logic [7:0] v;
        res.status = ST_OK;
        res.cx     = 8'd0;
        res.cy     = 8'd0;
        if (msg_count == 16'd0) begin
            msg_mode = md;
        end
        idx = int'(msg_count);
        if (idx >= MAX_LEN) begin
            msg_long = 1'b1;
        end
        // age bytes are skipped, checksum bytes count as zero when generating
        if (idx >= int'(AGE_BYTES)) begin
            v = (msg_mode && (idx == 16 || idx == 17)) ? 8'd0 : b;
            run_a = 8'((int'(run_a) + int'(v)) % 255);
            run_b = 8'((int'(run_b) + int'(run_a)) % 255);
        end
        if (msg_count != COUNT_MAX) begin
            msg_count = msg_count + 16'd1;
        end
        if (!lst) begin
            return 1'b0;
        end
        len = idx + 1;
        if (msg_long) begin
            res.status = ST_LONG;
        end else if (len < MIN_LEN) begin
            res.status = ST_SHORT;
        end else if (!msg_mode) begin
            res.status = (run_a == 8'd0 && run_b == 8'd0) ? ST_OK : ST_MISMATCH;
        end else begin
            x = ((len - 17) * int'(run_a) - int'(run_b)) % 255;
            if (x <= 0) begin
                x = x + 255;
            end
            y = 510 - int'(run_a) - x;
            if (y > 255) begin
                y = y - 255;
            end
            res.cx = x[7:0];
            res.cy = y[7:0];
        end
        msg_count = '0;
        run_a     = '0;
        run_b     = '0;
        msg_mode  = 1'b0;
        msg_long  = 1'b0;
        return 1'b1;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // fill the message buffer; sealed messages carry a valid checksum at 16/17
    function automatic void build_message(input int len, input fill_kind_t fill,
                                          input bit corrupt);
        chk_result_t seal;
        int          pos;
        logic [7:0]  fill_byte;
        msg_q.delete();
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: fill_byte = 8'h00;
                FILL_ONES: fill_byte = 8'hFF;
                default:   fill_byte = rand_byte();
            endcase
            msg_q = {msg_q, fill_byte};
        end
        if (fill == FILL_SEALED) begin
            for (int i = 0; i < len; i++) begin
                void'(fletcher_predict(1'b1, msg_q[i], i == len - 1, seal));
            end
            msg_q[16] = seal.cx;
            msg_q[17] = seal.cy;
        end
        if (corrupt) begin
            pos        = $urandom_range(0, len - 1);
            msg_q[pos] = msg_q[pos] + 8'($urandom_range(1, 255));
        end
    endfunction

    // hold off the sender until every pending result has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // stream the buffered message, one transaction per byte
    task automatic send_message(input logic md, input bit typed, input chk_result_t typed_res,
                                inout int sent);
        chk_result_t pred;
        chk_result_t exp_res;
        logic        cur_md;
        logic        cur_last;
        int          gap;
        for (int i = 0; i < msg_q.size(); i++) begin
            gap = pick_gap();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // mode only matters on the first byte, so scramble it elsewhere
            cur_md   = (i == 0) ? md : 1'($urandom_range(0, 1));
            cur_last = (i == msg_q.size() - 1);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= msg_q[i];
            s_axis_tuser  <= cur_md;
            s_axis_tlast  <= cur_last;
            do @(posedge aclk); while (!s_axis_tready);
            sent++;
            if (fletcher_predict(cur_md, msg_q[i], cur_last, pred)) begin
                exp_res         = typed ? typed_res : pred;
                pending_results = {pending_results, exp_res};
            end
        end
    endtask

    // result side back-pressure
    always @(posedge aclk) begin : sink_stall
        int g;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            g = pick_gap();
            m_axis_tready <= (g == 0);
            stall_left    <= (g > 0) ? g - 1 : 0;
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        chk_result_t got;
        chk_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status = lfc_status_t'(m_axis_tuser);
            got.cx     = m_axis_tdata[7:0];
            got.cy     = m_axis_tdata[15:8];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with nothing pending: status=%0d x=%0d y=%0d",
                             $realtime, got.status, got.cx, got.cy);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.cx !== want.cx || got.cy !== want.cy)
                begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: exp status=%0d x=%0d y=%0d, got status=%0d x=%0d y=%0d",
                                 $realtime, want.status, want.cx, want.cy,
                                 got.status, got.cx, got.cy);
                    end
                end
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[lsa_fletcher_checksum] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        chk_result_t typed_res;
        fill_kind_t  fill;
        int          sent;
        int          len;
        int          r;
        logic        md;
        bit          corrupt;
        sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed messages: lengths around the minimum, both modes
        foreach (DIRECTED[i]) begin
            quiet_run = (DIRECTED[i].len > 1000);
            build_message(int'(DIRECTED[i].len), DIRECTED[i].fill, 1'b0);
            typed_res.status = DIRECTED[i].st;
            typed_res.cx     = DIRECTED[i].x;
            typed_res.cy     = DIRECTED[i].y;
            send_message(DIRECTED[i].md, DIRECTED[i].typed, typed_res, sent);
        end
        quiet_run = 1'b0;
        wait_drained();

        // random messages: mostly sealed verifies and generates, some short or broken
        sent = 0;
        while (sent < RAND_BYTES) begin
            quiet_run = ($urandom_range(0, 5) == 0);
            r         = $urandom_range(0, 99);
            md        = 1'($urandom_range(0, 1));
            corrupt   = 1'b0;
            fill      = FILL_RAND;
            if (r < 8) begin
                len = $urandom_range(1, MIN_LEN - 1);
            end else begin
                len = (r < 13) ? $urandom_range(MIN_LEN, 300) : $urandom_range(MIN_LEN, 48);
                if (!md && $urandom_range(0, 9) < 6) begin
                    fill    = FILL_SEALED;
                    corrupt = ($urandom_range(0, 3) == 0);
                end
            end
            build_message(len, fill, corrupt);
            send_message(md, 1'b0, typed_res, sent);
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end
        quiet_run = 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[lsa_fletcher_checksum] OK");
        end else begin
            $display("[lsa_fletcher_checksum] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/lfc_pkg.sv
rtl/lfc_accum.sv
rtl/lfc_finish.sv
rtl/lsa_fletcher_checksum.sv
dv/tb_lsa_fletcher_checksum.sv
